### rtl/altvk_pkg.sv
// types, constants and micro-op sequence of the altitude/velocity kalman unit
package altvk_pkg;

   localparam int unsigned WORD_W     = 48;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned PC_W       = 5;
   localparam int unsigned SRC_W      = 5;

   localparam logic [PC_W-1:0] LAST_UOP = 5'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_STEP_SQ  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_POS_POS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_POS_VEL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_VEL_VEL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BARO_VARIANCE = 3'd5;

   localparam logic [31:0]       STEP_TIME_RST     = 32'd17179869;
   localparam logic [31:0]       HALF_STEP_SQ_RST  = 32'd34360;
   localparam logic [WORD_W-1:0] BARO_VARIANCE_RST = 48'h0001_0000_0000;

   typedef enum logic [2:0] {
      OP_MULADD,
      OP_MULSUB,
      OP_ADD,
      OP_SUB,
      OP_DIV
   } op_kind_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_ALT,
      SRC_VEL,
      SRC_P00,
      SRC_P01,
      SRC_P10,
      SRC_P11,
      SRC_TMP,
      SRC_K0,
      SRC_K1,
      SRC_DT,
      SRC_HDT2,
      SRC_ACC,
      SRC_MEAS,
      SRC_QPP,
      SRC_QPV,
      SRC_QVV,
      SRC_RVAR,
      SRC_ZERO
   } src_type;

   typedef struct packed {
      op_kind_type kind;
      src_type     a;
      src_type     b;
      src_type     c;
      src_type     dst;
      logic        sh32;
   } uop_type;

   // dst = c +/- round(a*b >> sh), dst = c +/- b, or dst = a / b (c unused)
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_TMP, 1'b0};
      case (pc)
         5'd0:  u = '{OP_MULADD, SRC_DT,   SRC_VEL,  SRC_ALT,  SRC_ALT, 1'b1};
         5'd1:  u = '{OP_MULADD, SRC_HDT2, SRC_ACC,  SRC_ALT,  SRC_ALT, 1'b0};
         5'd2:  u = '{OP_MULADD, SRC_DT,   SRC_ACC,  SRC_VEL,  SRC_VEL, 1'b0};
         5'd3:  u = '{OP_MULADD, SRC_DT,   SRC_P10,  SRC_P00,  SRC_P00, 1'b1};
         5'd4:  u = '{OP_MULADD, SRC_DT,   SRC_P11,  SRC_P01,  SRC_P01, 1'b1};
         5'd5:  u = '{OP_MULADD, SRC_P01,  SRC_DT,   SRC_P00,  SRC_P00, 1'b1};
         5'd6:  u = '{OP_ADD,    SRC_ZERO, SRC_QPP,  SRC_P00,  SRC_P00, 1'b0};
         5'd7:  u = '{OP_ADD,    SRC_ZERO, SRC_QPV,  SRC_P01,  SRC_P01, 1'b0};
         5'd8:  u = '{OP_MULADD, SRC_P11,  SRC_DT,   SRC_P10,  SRC_P10, 1'b1};
         5'd9:  u = '{OP_ADD,    SRC_ZERO, SRC_QPV,  SRC_P10,  SRC_P10, 1'b0};
         5'd10: u = '{OP_ADD,    SRC_ZERO, SRC_QVV,  SRC_P11,  SRC_P11, 1'b0};
         5'd11: u = '{OP_ADD,    SRC_ZERO, SRC_RVAR, SRC_P00,  SRC_TMP, 1'b0};
         5'd12: u = '{OP_DIV,    SRC_P00,  SRC_TMP,  SRC_ZERO, SRC_K0,  1'b0};
         5'd13: u = '{OP_DIV,    SRC_P10,  SRC_TMP,  SRC_ZERO, SRC_K1,  1'b0};
         5'd14: u = '{OP_SUB,    SRC_ZERO, SRC_ALT,  SRC_MEAS, SRC_TMP, 1'b0};
         5'd15: u = '{OP_MULADD, SRC_K0,   SRC_TMP,  SRC_ALT,  SRC_ALT, 1'b1};
         5'd16: u = '{OP_MULADD, SRC_K1,   SRC_TMP,  SRC_VEL,  SRC_VEL, 1'b1};
         5'd17: u = '{OP_MULSUB, SRC_K1,   SRC_P00,  SRC_P10,  SRC_P10, 1'b1};
         5'd18: u = '{OP_MULSUB, SRC_K1,   SRC_P01,  SRC_P11,  SRC_P11, 1'b1};
         5'd19: u = '{OP_MULSUB, SRC_K0,   SRC_P00,  SRC_P00,  SRC_P00, 1'b1};
         5'd20: u = '{OP_MULSUB, SRC_K0,   SRC_P01,  SRC_P01,  SRC_P01, 1'b1};
         default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_TMP, 1'b0};
      endcase
      return u;
   endfunction

endpackage

### rtl/altitude_velocity_kalman_unit.sv
// two-state altitude/velocity kalman filter over one shared multiply/divide unit
//
// usage
//   request channel  req_valid/req_ready carries one barometric altitude and one
//   vertical acceleration (signed Q16.16). response channel rsp_valid/rsp_ready
//   returns the filtered altitude and velocity (signed Q16.16, saturated), one
//   response per request, in order.
//   csr_wr_en/csr_index/csr_wdata write the tuning registers, only while idle; the block does not enforce this.
// timing
//   a sequencer steps through 21 micro-ops on one 24x24 multiplier, one 51 bit
//   adder and one restoring divider. a multiply op accumulates its partial
//   products, rounds and adds; a gain division checks, shifts out its quotient
//   bits, rounds and adds, skipping the bits when the divisor is zero or the
//   gain saturates. a new request is taken only once the last is through;
//   req_ready is high only between requests.
// reset
//   state and covariance clear to zero, registers take their defaults and no
//   response is pending.
// stall
//   a finished response waits in its output register; a new request is taken
//   meanwhile and only its own response waits for the register to free up.
module altitude_velocity_kalman_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [31:0]                   req_measured_altitude,
   input  logic signed [31:0]                   req_vertical_accel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_altitude_estimate,
   output logic signed [31:0]                   rsp_velocity_estimate,
   input  logic                                 csr_wr_en,
   input  logic [altvk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [altvk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SETUP    = 9'b000000010,
      ST_MUL      = 9'b000000100,
      ST_MUL_FIN  = 9'b000001000,
      ST_DIV_CHK  = 9'b000010000,
      ST_DIV_ITER = 9'b000100000,
      ST_DIV_FIN  = 9'b001000000,
      ST_ALU      = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   localparam logic [5:0]  DIV_LAST = 6'd47;
   localparam logic [95:0] RND32    = 96'h1 << 31;
   localparam logic [95:0] RND16    = 96'h1 << 15;
   localparam logic [47:0] LIM_POS  = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] LIM_NEG  = 48'h8000_0000_0000;
   localparam logic signed [50:0] SUM_MAX = 51'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [50:0] SUM_MIN = 51'sh7_8000_0000_0000;

   function automatic logic [47:0] mag49(input logic signed [48:0] v);
      logic [48:0] t;
      t = v[48] ? 49'(-v) : v;
      return t[47:0];
   endfunction

   function automatic logic [31:0] rnd_q16(input logic signed [47:0] x);
      logic signed [48:0] t;
      t = {x[47], x} + 49'sd32768;
      if (!t[48] && (t[47:47] != 1'b0)) begin
         return 32'h7FFF_FFFF;
      end
      return t[47:16];
   endfunction

   state_type state_ff, state_in;
   logic [altvk_pkg::PC_W-1:0] pc_ff, pc_in;

   logic signed [47:0] alt_ff, alt_in, vel_ff, vel_in;
   logic signed [47:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [47:0] tmp_ff, tmp_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] meas_ff, meas_in, accel_ff, accel_in;

   logic [31:0] step_time_ff, step_time_in, half_step_sq_ff, half_step_sq_in;
   logic [47:0] q_pos_pos_ff, q_pos_pos_in, q_pos_vel_ff, q_pos_vel_in;
   logic [47:0] q_vel_vel_ff, q_vel_vel_in, baro_variance_ff, baro_variance_in;

   logic [47:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [95:0]        prodacc_ff, prodacc_in;
   logic signed [48:0] prod_ff, prod_in;
   logic [47:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic [15:0]        dvd_ff, dvd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_alt_ff, rsp_alt_in, rsp_vel_ff, rsp_vel_in;

   altvk_pkg::uop_type uop;
   logic signed [48:0] opnd [32];
   logic signed [48:0] opa, opb, opc, bsel;
   logic signed [50:0] sum;
   logic signed [47:0] sum_sat;
   logic               is_sub;
   logic [23:0]        pa, pb;
   logic [47:0]        pp;
   logic [95:0]        part_sh, rnd, q96;
   logic [47:0]        lim, qsat;
   logic [48:0]        trial, q2;
   logic               rsp_take;

   assign uop = altvk_pkg::uop_rom(pc_ff);

   always_comb begin
      for (int i = 0; i < 32; i++) begin
         opnd[i] = '0;
      end
      opnd[altvk_pkg::SRC_ALT]  = {alt_ff[47], alt_ff};
      opnd[altvk_pkg::SRC_VEL]  = {vel_ff[47], vel_ff};
      opnd[altvk_pkg::SRC_P00]  = {p00_ff[47], p00_ff};
      opnd[altvk_pkg::SRC_P01]  = {p01_ff[47], p01_ff};
      opnd[altvk_pkg::SRC_P10]  = {p10_ff[47], p10_ff};
      opnd[altvk_pkg::SRC_P11]  = {p11_ff[47], p11_ff};
      opnd[altvk_pkg::SRC_TMP]  = {tmp_ff[47], tmp_ff};
      opnd[altvk_pkg::SRC_K0]   = {k0_ff[47], k0_ff};
      opnd[altvk_pkg::SRC_K1]   = {k1_ff[47], k1_ff};
      opnd[altvk_pkg::SRC_DT]   = {17'b0, step_time_ff};
      opnd[altvk_pkg::SRC_HDT2] = {17'b0, half_step_sq_ff};
      opnd[altvk_pkg::SRC_ACC]  = {{17{accel_ff[31]}}, accel_ff};
      opnd[altvk_pkg::SRC_MEAS] = {meas_ff[31], meas_ff, 16'b0};
      opnd[altvk_pkg::SRC_QPP]  = {1'b0, q_pos_pos_ff};
      opnd[altvk_pkg::SRC_QPV]  = {1'b0, q_pos_vel_ff};
      opnd[altvk_pkg::SRC_QVV]  = {1'b0, q_vel_vel_ff};
      opnd[altvk_pkg::SRC_RVAR] = {1'b0, baro_variance_ff};
      opa = opnd[uop.a];
      opb = opnd[uop.b];
      opc = opnd[uop.c];
   end

   // shared datapath pieces
   always_comb begin
      pa = cnt_ff[1] ? mag_a_ff[47:24] : mag_a_ff[23:0];
      pb = cnt_ff[0] ? mag_b_ff[47:24] : mag_b_ff[23:0];
      pp = pa * pb;
      case (cnt_ff[1:0])
         2'd0:    part_sh = {48'b0, pp};
         2'd3:    part_sh = {pp, 48'b0};
         default: part_sh = {24'b0, pp, 24'b0};
      endcase
      rnd = prodacc_ff + (uop.sh32 ? RND32 : RND16);
      q96 = uop.sh32 ? (rnd >> 32) : (rnd >> 16);
      lim = neg_ff ? LIM_NEG : LIM_POS;
      qsat = (q96 > {48'b0, lim}) ? lim : q96[47:0];

      is_sub = (uop.kind == altvk_pkg::OP_SUB) || (uop.kind == altvk_pkg::OP_MULSUB);
      bsel = ((uop.kind == altvk_pkg::OP_ADD) || (uop.kind == altvk_pkg::OP_SUB)) ?
             opb : prod_ff;
      sum = is_sub ? ({{2{opc[48]}}, opc} - {{2{bsel[48]}}, bsel}) :
                     ({{2{opc[48]}}, opc} + {{2{bsel[48]}}, bsel});
      if (sum > SUM_MAX) begin
         sum_sat = SUM_MAX[47:0];
      end else if (sum < SUM_MIN) begin
         sum_sat = SUM_MIN[47:0];
      end else begin
         sum_sat = sum[47:0];
      end

      trial = {rem_ff, dvd_ff[15]};
      q2 = {1'b0, quo_ff} + {48'b0, ({rem_ff, 1'b0} >= {1'b0, mag_b_ff})};
   end

   assign rsp_take = rsp_valid_ff && rsp_ready;

   always_comb begin
      state_in         = state_ff;
      pc_in            = pc_ff;
      alt_in           = alt_ff;
      vel_in           = vel_ff;
      p00_in           = p00_ff;
      p01_in           = p01_ff;
      p10_in           = p10_ff;
      p11_in           = p11_ff;
      tmp_in           = tmp_ff;
      k0_in            = k0_ff;
      k1_in            = k1_ff;
      meas_in          = meas_ff;
      accel_in         = accel_ff;
      mag_a_in         = mag_a_ff;
      mag_b_in         = mag_b_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      prodacc_in       = prodacc_ff;
      prod_in          = prod_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      dvd_in           = dvd_ff;
      rsp_valid_in     = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_alt_in       = rsp_alt_ff;
      rsp_vel_in       = rsp_vel_ff;
      step_time_in     = step_time_ff;
      half_step_sq_in  = half_step_sq_ff;
      q_pos_pos_in     = q_pos_pos_ff;
      q_pos_vel_in     = q_pos_vel_ff;
      q_vel_vel_in     = q_vel_vel_ff;
      baro_variance_in = baro_variance_ff;

      if (csr_wr_en) begin
         case (csr_index)
            altvk_pkg::CSR_STEP_TIME:     step_time_in     = csr_wdata[31:0];
            altvk_pkg::CSR_HALF_STEP_SQ:  half_step_sq_in  = csr_wdata[31:0];
            altvk_pkg::CSR_Q_POS_POS:     q_pos_pos_in     = csr_wdata;
            altvk_pkg::CSR_Q_POS_VEL:     q_pos_vel_in     = csr_wdata;
            altvk_pkg::CSR_Q_VEL_VEL:     q_vel_vel_in     = csr_wdata;
            altvk_pkg::CSR_BARO_VARIANCE: baro_variance_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = req_measured_altitude;
               accel_in = req_vertical_accel;
               pc_in    = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            mag_a_in   = mag49(opa);
            mag_b_in   = mag49(opb);
            neg_in     = opa[48] ^ opb[48];
            prodacc_in = '0;
            cnt_in     = '0;
            case (uop.kind)
               altvk_pkg::OP_MULADD, altvk_pkg::OP_MULSUB: state_in = ST_MUL;
               altvk_pkg::OP_DIV:                          state_in = ST_DIV_CHK;
               default:                                    state_in = ST_ALU;
            endcase
         end
         ST_MUL: begin
            prodacc_in = prodacc_ff + part_sh;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_MUL_FIN;
            end
         end
         ST_MUL_FIN: begin
            prod_in  = neg_ff ? 49'(-$signed({1'b0, qsat})) : {1'b0, qsat};
            state_in = ST_ALU;
         end
         ST_DIV_CHK: begin
            if (mag_b_ff == '0) begin
               prod_in  = '0;
               state_in = ST_ALU;
            end else if ({16'b0, mag_a_ff} >= {mag_b_ff, 16'b0}) begin
               prod_in  = neg_ff ? 49'(-$signed({1'b0, lim})) : {1'b0, lim};
               state_in = ST_ALU;
            end else begin
               rem_in   = {16'b0, mag_a_ff[47:16]};
               dvd_in   = mag_a_ff[15:0];
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV_ITER;
            end
         end
         ST_DIV_ITER: begin
            if (trial >= {1'b0, mag_b_ff}) begin
               rem_in = 48'(trial - {1'b0, mag_b_ff});
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = trial[47:0];
               quo_in = {quo_ff[46:0], 1'b0};
            end
            dvd_in = {dvd_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            if (q2 > {1'b0, lim}) begin
               prod_in = neg_ff ? 49'(-$signed({1'b0, lim})) : {1'b0, lim};
            end else begin
               prod_in = neg_ff ? 49'(-$signed(q2)) : q2;
            end
            state_in = ST_ALU;
         end
         ST_ALU: begin
            case (uop.dst)
               altvk_pkg::SRC_ALT: alt_in = sum_sat;
               altvk_pkg::SRC_VEL: vel_in = sum_sat;
               altvk_pkg::SRC_P00: p00_in = sum_sat;
               altvk_pkg::SRC_P01: p01_in = sum_sat;
               altvk_pkg::SRC_P10: p10_in = sum_sat;
               altvk_pkg::SRC_P11: p11_in = sum_sat;
               altvk_pkg::SRC_K0:  k0_in  = sum_sat;
               altvk_pkg::SRC_K1:  k1_in  = sum_sat;
               default:            tmp_in = sum_sat;
            endcase
            if (pc_ff == altvk_pkg::LAST_UOP) begin
               state_in = ST_DONE;
            end else begin
               pc_in    = pc_ff + 5'd1;
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in   = rnd_q16(alt_ff);
               rsp_vel_in   = rnd_q16(vel_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pc_ff            <= '0;
         alt_ff           <= '0;
         vel_ff           <= '0;
         p00_ff           <= '0;
         p01_ff           <= '0;
         p10_ff           <= '0;
         p11_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         step_time_ff     <= altvk_pkg::STEP_TIME_RST;
         half_step_sq_ff  <= altvk_pkg::HALF_STEP_SQ_RST;
         q_pos_pos_ff     <= '0;
         q_pos_vel_ff     <= '0;
         q_vel_vel_ff     <= '0;
         baro_variance_ff <= altvk_pkg::BARO_VARIANCE_RST;
         cnt_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         pc_ff            <= pc_in;
         alt_ff           <= alt_in;
         vel_ff           <= vel_in;
         p00_ff           <= p00_in;
         p01_ff           <= p01_in;
         p10_ff           <= p10_in;
         p11_ff           <= p11_in;
         rsp_valid_ff     <= rsp_valid_in;
         step_time_ff     <= step_time_in;
         half_step_sq_ff  <= half_step_sq_in;
         q_pos_pos_ff     <= q_pos_pos_in;
         q_pos_vel_ff     <= q_pos_vel_in;
         q_vel_vel_ff     <= q_vel_vel_in;
         baro_variance_ff <= baro_variance_in;
         cnt_ff           <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff     <= tmp_in;
      k0_ff      <= k0_in;
      k1_ff      <= k1_in;
      meas_ff    <= meas_in;
      accel_ff   <= accel_in;
      mag_a_ff   <= mag_a_in;
      mag_b_ff   <= mag_b_in;
      neg_ff     <= neg_in;
      prodacc_ff <= prodacc_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvd_ff     <= dvd_in;
      rsp_alt_ff <= rsp_alt_in;
      rsp_vel_ff <= rsp_vel_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_altitude_estimate = rsp_alt_ff;
   assign rsp_velocity_estimate = rsp_vel_ff;

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= altvk_pkg::LAST_UOP)
      else $error("micro-op counter out of range");

   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SETUP && pc_ff == '0)
      else $error("request did not start the sequence at its first op");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_ITER |-> cnt_ff <= DIV_LAST)
      else $error("divider ran past its last quotient bit");

endmodule
